[rtl/core/sipq_pkg.sv]
// Package for the sorted insert priority queue.
// Holds the sizes, the entry type, the status codes, the operation codes and the state encoding.
// Depends on nothing; the interfaces and the top level import it.
`default_nettype none

package sipq_pkg;

	// Built sizes of the queue.
	localparam int DEPTH      = 16;
	localparam int PRIO_BITS  = 8;
	localparam int VALUE_BITS = 16;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CAP_W      = 5;

	localparam logic [CAP_W-1:0] DEPTH_CAP = CAP_W'(DEPTH);

	// One stored pair.
	typedef struct packed {
		logic [PRIO_BITS-1:0]  prio;
		logic [VALUE_BITS-1:0] value;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Operation codes of the mode field.
	localparam logic MODE_ADD = 1'b0;
	localparam logic MODE_DEL = 1'b1;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD_CMP,
		S_ADD_FIN,
		S_DEL_DATA,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

[rtl/core/sipq_if.sv]
// Channel interfaces of the sorted insert priority queue.
// Request, response and configuration channels with valid and ready.
// Depends on sipq_pkg.
`default_nettype none

interface sipq_req_if;
	import sipq_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  mode;
	logic [PRIO_BITS-1:0]  in_priority;
	logic [VALUE_BITS-1:0] in_value;

	modport source (output valid, mode, in_priority, in_value, input ready);
	modport sink   (input valid, mode, in_priority, in_value, output ready);
endinterface

interface sipq_rsp_if;
	import sipq_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [PRIO_BITS-1:0]  out_priority;
	logic [VALUE_BITS-1:0] out_value;
	logic                  removed;
	status_t               status;
	logic [CAP_W-1:0]      occupancy;

	modport source (output valid, out_priority, out_value, removed, status, occupancy,
		input ready);
	modport sink   (input valid, out_priority, out_value, removed, status, occupancy,
		output ready);
endinterface

interface sipq_cfg_if;
	import sipq_pkg::*;

	logic             valid;
	logic             ready;
	logic [CAP_W-1:0] capacity;

	modport source (output valid, capacity, input ready);
	modport sink   (input valid, capacity, output ready);
endinterface

`default_nettype wire

[rtl/core/sipq_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// Width and depth are parameters; no package is used.
`default_nettype none

module sipq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[rtl/core/sorted_insert_priority_queue.sv]
// Top level of the sorted insert priority queue.
// Depends on sipq_pkg, the interfaces in sipq_if and the RAM in sipq_ram.
//
// Usage:
// The req channel carries one word per operation: mode selects add or remove
// head, and in_priority and in_value give the pair to add. The rsp channel
// returns one word per request with the removed pair (zero on an add), the
// removed flag, a status code and the occupancy after the operation. The cfg
// channel writes the capacity (saturated to 1..DEPTH) and empties the queue;
// it is always ready; the user must write it only while the block is idle,
// which the block itself does not enforce. One request is handled at a
// time; req.ready is high only when the sequencer is idle. Refused operations
// and an add to an empty queue go straight to the done state, a remove reads
// its pair in a data state first, and any other add walks the new pair toward
// the head one entry per cycle, limited by the single read port of the entry
// RAM and the one priority comparator. The finished word sits in an output
// register, so a stalled receiver does not hold the next request until a
// second result is ready; then the sequencer waits in its done state.
// Reset clears the pointers, the count and the output valid; capacity
// returns to DEPTH. The RAM contents are undefined but never read unwritten.
`default_nettype none

module sorted_insert_priority_queue (
	input wire logic clk,
	input wire logic arst_n,
	sipq_req_if.sink   req,
	sipq_rsp_if.source rsp,
	sipq_cfg_if.sink   cfg
);
	import sipq_pkg::*;

	// Ring index helpers over the configured capacity.
	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx,
		input logic [CAP_W-1:0] cap);
		logic [CAP_W-1:0] last;
		last = cap - CAP_W'(1);
		return (CAP_W'(idx) == last) ? '0 : idx + IDX_W'(1);
	endfunction

	function automatic logic [IDX_W-1:0] prev_idx(input logic [IDX_W-1:0] idx,
		input logic [CAP_W-1:0] cap);
		logic [CAP_W-1:0] last;
		last = cap - CAP_W'(1);
		return (idx == '0) ? last[IDX_W-1:0] : idx - IDX_W'(1);
	endfunction

	state_t state_q, state_d;

	logic [CAP_W-1:0] cap_q;
	logic [CAP_W-1:0] count_q;
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;
	logic [IDX_W-1:0] walk_q;
	entry_t           new_q;

	// Pending result of the item at work.
	entry_t  res_entry_q;
	logic    res_removed_q;
	status_t res_status_q;

	// Output register.
	logic                  out_valid_q;
	logic [PRIO_BITS-1:0]  out_prio_q;
	logic [VALUE_BITS-1:0] out_value_q;
	logic                  out_removed_q;
	status_t               out_status_q;
	logic [CAP_W-1:0]      out_occ_q;

	// RAM port signals.
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	entry_t           ram_wdata;
	logic [IDX_W-1:0] ram_raddr;
	entry_t           ram_rdata;

	logic             req_acc;
	logic             cfg_acc;
	logic             is_full;
	logic             is_empty;
	logic [IDX_W-1:0] add_slot;
	logic [IDX_W-1:0] walk_prev;
	logic             move_up;
	logic             out_load;
	entry_t           in_entry;

	sipq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Handshakes and shared decode.
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign req_acc   = req.valid && req.ready;
	assign cfg_acc   = cfg.valid && cfg.ready;
	assign is_full   = (count_q >= cap_q);
	assign is_empty  = (count_q == '0);
	assign add_slot  = next_idx(tail_q, cap_q);
	assign walk_prev = prev_idx(walk_q, cap_q);
	assign move_up   = (ram_rdata.prio < new_q.prio);
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || rsp.ready);
	assign in_entry  = '{prio: req.in_priority, value: req.in_value};

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					if (req.mode == MODE_DEL) begin
						state_d = is_empty ? S_DONE : S_DEL_DATA;
					end else if (is_full || is_empty) begin
						state_d = S_DONE;
					end else begin
						state_d = S_ADD_CMP;
					end
				end
			end
			S_ADD_CMP: begin
				if (!move_up) begin
					state_d = S_DONE;
				end else if (walk_prev == head_q) begin
					state_d = S_ADD_FIN;
				end else begin
					state_d = S_ADD_CMP;
				end
			end
			S_ADD_FIN:  state_d = S_DONE;
			S_DEL_DATA: state_d = S_DONE;
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// RAM controls for each state.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = walk_q;
		ram_wdata = new_q;
		ram_raddr = prev_idx(walk_prev, cap_q);
		unique case (state_q)
			S_IDLE: begin
				if (req.mode == MODE_DEL) begin
					ram_raddr = head_q;
				end else begin
					ram_raddr = prev_idx(add_slot, cap_q);
				end
				// The first pair of an empty queue goes straight to slot zero.
				if (req_acc && req.mode == MODE_ADD && is_empty) begin
					ram_we    = 1'b1;
					ram_waddr = '0;
					ram_wdata = in_entry;
				end
			end
			S_ADD_CMP: begin
				ram_we    = 1'b1;
				ram_wdata = move_up ? ram_rdata : new_q;
			end
			S_ADD_FIN: begin
				ram_we = 1'b1;
			end
			S_DEL_DATA, S_DONE: begin
				ram_we = 1'b0;
			end
			default: ram_we = 1'b0;
		endcase
	end

	// Sequencer, queue pointers and pending result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cap_q         <= DEPTH_CAP;
			count_q       <= '0;
			head_q        <= '0;
			tail_q        <= '0;
			res_removed_q <= 1'b0;
			res_status_q  <= ST_OK;
		end else begin
			state_q <= state_d;
			if (cfg_acc) begin
				if (cfg.capacity == '0) begin
					cap_q <= CAP_W'(1);
				end else if (cfg.capacity > DEPTH_CAP) begin
					cap_q <= DEPTH_CAP;
				end else begin
					cap_q <= cfg.capacity;
				end
				count_q <= '0;
				head_q  <= '0;
				tail_q  <= '0;
			end else if (req_acc) begin
				res_removed_q <= 1'b0;
				res_status_q  <= ST_OK;
				if (req.mode == MODE_ADD) begin
					if (is_full) begin
						res_status_q <= ST_FULL;
					end else if (is_empty) begin
						head_q  <= '0;
						tail_q  <= '0;
						count_q <= CAP_W'(1);
					end else begin
						tail_q  <= add_slot;
						count_q <= count_q + CAP_W'(1);
					end
				end else begin
					if (is_empty) begin
						res_status_q <= ST_EMPTY;
					end else begin
						res_removed_q <= 1'b1;
						count_q       <= count_q - CAP_W'(1);
						// The queue returns to slot zero once it runs empty.
						if (count_q == CAP_W'(1)) begin
							head_q <= '0;
							tail_q <= '0;
						end else begin
							head_q <= next_idx(head_q, cap_q);
						end
					end
				end
			end
		end
	end

	// Walk position, the pair being placed and the removed pair.
	always_ff @(posedge clk) begin
		if (req_acc) begin
			new_q       <= in_entry;
			walk_q      <= add_slot;
			res_entry_q <= '0;
		end else if (state_q == S_ADD_CMP && move_up) begin
			walk_q <= walk_prev;
		end else if (state_q == S_DEL_DATA) begin
			res_entry_q <= ram_rdata;
		end
	end

	// Output register valid, freed when the receiver takes the word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_prio_q    <= res_entry_q.prio;
			out_value_q   <= res_entry_q.value;
			out_removed_q <= res_removed_q;
			out_status_q  <= res_status_q;
			out_occ_q     <= count_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.out_priority = out_prio_q;
	assign rsp.out_value    = out_value_q;
	assign rsp.removed      = out_removed_q;
	assign rsp.status       = out_status_q;
	assign rsp.occupancy    = out_occ_q;

	// The count never passes the configured capacity.
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cap_q)
		else $error("entry count above capacity");

	// An empty queue always has both pointers at slot zero.
	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (head_q == '0 && tail_q == '0))
		else $error("empty queue with pointers off slot zero");

	// An accepted add into a queue with room grows the count by one.
	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && req.mode == MODE_ADD && !is_full)
		|=> (count_q == $past(count_q) + CAP_W'(1)))
		else $error("add did not grow the count");

	// A word that carries a removed pair reports success.
	a_removed_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.removed) |-> (rsp.status == ST_OK))
		else $error("removed pair with failure status");

endmodule

`default_nettype wire
